// ----- rtl/egd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the Exp-Golomb stream decoder.
// No dependencies; used by every module of the block.
package egd_pkg;

  localparam int BYTE_W               = 8;
  localparam int POS_W                = 3;
  localparam int END_W                = 4;
  localparam int VALUE_W              = 21;
  localparam int COUNT_W              = 5;
  localparam int NUM_SLOTS            = 8;
  localparam int DEF_MAX_PREFIX_ZEROS = 20;

  typedef struct packed {
    logic               in_suffix;
    logic [COUNT_W-1:0] zero_count;
    logic [VALUE_W-1:0] suffix_acc;
    logic [COUNT_W-1:0] bits_remaining;
  } egd_state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               err;
    logic [END_W-1:0]   end_bit;
  } egd_result_t;

  localparam egd_state_t STATE_CLEAR = '{
    in_suffix:      1'b0,
    zero_count:     '0,
    suffix_acc:     VALUE_W'(1),
    bits_remaining: '0
  };

endpackage

// ----- rtl/egd_scan.sv -----
`timescale 1ns / 1ps
// Unrolled eight-bit codeword scan: next decoder state and one result slot per bit.
// Depends on egd_pkg.
module egd_scan #(
  parameter int MAX_PREFIX_ZEROS = egd_pkg::DEF_MAX_PREFIX_ZEROS
) (
  input  logic [egd_pkg::BYTE_W-1:0]                      data_byte,
  input  logic                                            restart,
  input  logic [egd_pkg::POS_W-1:0]                       start_bit,
  input  egd_pkg::egd_state_t                             state,
  output egd_pkg::egd_state_t                             state_next,
  output egd_pkg::egd_result_t [egd_pkg::NUM_SLOTS-1:0]   slots,
  output logic [egd_pkg::NUM_SLOTS-1:0]                   mask
);
  import egd_pkg::*;

  localparam int CNT_W = COUNT_W + 1;

  always_comb begin
    egd_state_t       st;
    logic             bit_val;
    logic [CNT_W-1:0] cnt;
    logic [VALUE_W-1:0] acc;
    st    = restart ? STATE_CLEAR : state;
    slots = '0;
    mask  = '0;
    for (int p = 0; p < NUM_SLOTS; p++) begin
      bit_val = data_byte[BYTE_W-1-p];
      cnt     = {1'b0, st.zero_count} + CNT_W'(1);
      acc     = {st.suffix_acc[VALUE_W-2:0], bit_val};
      slots[p].end_bit = END_W'(p + 1);
      if (!restart || (POS_W'(p) >= start_bit)) begin
        if (!st.in_suffix) begin
          if (!bit_val) begin
            if (cnt > CNT_W'(MAX_PREFIX_ZEROS)) begin
              mask[p]        = 1'b1;
              slots[p].err   = 1'b1;
              slots[p].value = '0;
              st             = STATE_CLEAR;
            end else begin
              st.zero_count = cnt[COUNT_W-1:0];
            end
          end else if (st.zero_count == '0) begin
            mask[p]        = 1'b1;
            slots[p].value = '0;
            st             = STATE_CLEAR;
          end else begin
            st.in_suffix      = 1'b1;
            st.bits_remaining = st.zero_count;
            st.suffix_acc     = VALUE_W'(1);
          end
        end else begin
          st.suffix_acc     = acc;
          st.bits_remaining = st.bits_remaining - COUNT_W'(1);
          if (st.bits_remaining == '0) begin
            mask[p]        = 1'b1;
            slots[p].value = acc - VALUE_W'(1);
            st             = STATE_CLEAR;
          end
        end
      end
    end
    state_next = st;
  end

endmodule

// ----- rtl/egd_buffer.sv -----
`timescale 1ns / 1ps
// Result buffer: holds the slots of one byte and drains them in bit order.
// Depends on egd_pkg.
module egd_buffer (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          load,
  input  egd_pkg::egd_result_t [egd_pkg::NUM_SLOTS-1:0] load_slots,
  input  logic [egd_pkg::NUM_SLOTS-1:0]                 load_mask,
  input  logic                                          take,
  output egd_pkg::egd_result_t                          head,
  output logic                                          head_valid,
  output logic                                          head_last
);
  import egd_pkg::*;

  egd_result_t [NUM_SLOTS-1:0] slots;
  logic [NUM_SLOTS-1:0]        mask;
  logic [NUM_SLOTS-1:0]        pick;
  logic [NUM_SLOTS-1:0]        mask_next;

  always_comb begin
    pick = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        pick = '0;
        pick[i] = 1'b1;
      end
    end
  end

  always_comb begin
    head = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (pick[i]) begin
        head = slots[i];
      end
    end
  end

  assign head_valid = |mask;
  assign head_last  = $onehot(mask);

  always_comb begin
    mask_next = mask;
    if (load) begin
      mask_next = load_mask;
    end else if (take) begin
      mask_next = mask & ~pick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= load_slots;
    end
  end

endmodule

// ----- rtl/exp_golomb_stream_decoder_unit.sv -----
`timescale 1ns / 1ps
// Exp-Golomb (unsigned) stream decoder, top level. Uses egd_pkg, egd_scan, egd_buffer.
// The first result of a byte is presented in the cycle after the byte transfer.
// A byte giving k results (k = 0..8) holds the output until all k are taken; the
// single result port drains one result per cycle while out_ready is high, so a byte
// is taken every cycle while each completes at most one codeword and out_ready holds.
// Reset: clears the partial codeword and empties the result buffer.
module exp_golomb_stream_decoder_unit #(
  parameter int MAX_PREFIX_ZEROS = egd_pkg::DEF_MAX_PREFIX_ZEROS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [egd_pkg::BYTE_W-1:0]    data_byte,
  input  logic                          restart,
  input  logic [egd_pkg::POS_W-1:0]     start_bit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [egd_pkg::VALUE_W-1:0]   code_value,
  output logic                          error,
  output logic [egd_pkg::END_W-1:0]     end_bit,
  output logic                          last
);
  import egd_pkg::*;

  egd_state_t                  state;
  egd_state_t                  state_next;
  egd_result_t [NUM_SLOTS-1:0] scan_slots;
  logic [NUM_SLOTS-1:0]        scan_mask;
  egd_result_t                 head;
  logic                        accept;

  egd_scan #(
    .MAX_PREFIX_ZEROS(MAX_PREFIX_ZEROS)
  ) u_scan (
    .data_byte (data_byte),
    .restart   (restart),
    .start_bit (start_bit),
    .state     (state),
    .state_next(state_next),
    .slots     (scan_slots),
    .mask      (scan_mask)
  );

  egd_buffer u_buffer (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .load_slots(scan_slots),
    .load_mask (scan_mask),
    .take      (out_valid && out_ready),
    .head      (head),
    .head_valid(out_valid),
    .head_last (last)
  );

  assign in_ready   = !out_valid || (last && out_ready);
  assign accept     = in_valid && in_ready;
  assign code_value = head.value;
  assign error      = head.err;
  assign end_bit    = head.end_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (accept) begin
      state <= state_next;
    end
  end

  a_load_when_drained: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!out_valid || (last && out_ready)))
    else $error("byte transfer while results still pending");

  a_error_zero_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (code_value == '0))
    else $error("error result carries nonzero value");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result buffer not empty after reset");

  a_suffix_count: assert property (@(posedge clk) disable iff (rst)
    (state.in_suffix == 1'b0) |-> (state.bits_remaining == '0))
    else $error("suffix count left over while counting prefix");

endmodule
